// ===== src/cwtp_pkg.sv =====
`default_nettype none

package cwtp_pkg;

  // Cache geometry
  localparam int unsigned NUM_SETS  = 4;
  localparam int unsigned NUM_WAYS  = 4;
  localparam int unsigned TAG_WIDTH = 26;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned WAY_W    = $clog2(NUM_WAYS);
  localparam int unsigned TREE_W   = NUM_WAYS - 1;
  localparam int unsigned HIT_W    = 16;
  localparam int unsigned SET_LSB  = 4;
  localparam int unsigned WORD_LSB = 2;
  localparam int unsigned WORD_W   = 2;
  localparam int unsigned TAG_LSB  = 6;

  typedef logic [SET_W-1:0]     set_t;
  typedef logic [WAY_W-1:0]     way_t;
  typedef logic [TREE_W-1:0]    tree_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [HIT_W-1:0]     hit_cnt_t;
  typedef logic [WAY_W:0]       node_t;

  // Contents of one set, as seen by the lookup
  typedef struct packed {
    logic [NUM_WAYS-1:0]          valid;
    logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] tags;
    tree_t                        tree;
  } set_row_t;

  // Lookup decision handed back to the store
  typedef struct packed {
    logic  hit;
    way_t  way;
    logic  evicted;
    tree_t tree_new;
  } lookup_t;

  // Point every tree node on the path to way w toward it (heap order)
  function automatic tree_t tree_touch(tree_t t, way_t w);
    node_t node;
    node_t parent;
    tree_t r;
    r    = t;
    node = node_t'(w) + node_t'(NUM_WAYS - 1);
    for (int i = 0; i < WAY_W; i++) begin
      parent = node_t'((node - 1'b1) >> 1);
      r[parent[WAY_W-1:0]] = ~node[0];
      node = parent;
    end
    return r;
  endfunction

  // Walk against the tree bits to the pseudo least recently used way
  function automatic way_t tree_victim(tree_t t);
    node_t node;
    node = '0;
    for (int i = 0; i < WAY_W; i++) begin
      if (t[node[WAY_W-1:0]]) node = node_t'({node, 1'b0} + 1'b1);
      else                    node = node_t'({node, 1'b0} + 2'd2);
    end
    return way_t'(node - node_t'(NUM_WAYS - 1));
  endfunction

endpackage

`default_nettype wire

// ===== src/cwtp_lookup.sv =====
`default_nettype none

module cwtp_lookup
  import cwtp_pkg::*;
(
  input  wire set_row_t row_i,
  input  wire tag_t     tag_i,
  output lookup_t       res_o
);

  logic [NUM_WAYS-1:0] match;
  logic                hit;
  logic                free_found;
  way_t                hit_way;
  way_t                free_way;
  way_t                way;

  // Compare all ways of the set at once
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = row_i.valid[w] && (row_i.tags[w] == tag_i);
    end
  end

  // Lowest matching way and lowest invalid way
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = way_t'(w);
      end
      if (!row_i.valid[w]) begin
        free_found = 1'b1;
        free_way   = way_t'(w);
      end
    end
  end

  // Way choice: hit, else fill, else evict the PLRU victim
  always_comb begin
    priority if (hit)   way = hit_way;
    else if (free_found) way = free_way;
    else                 way = tree_victim(row_i.tree);
  end

  assign res_o.hit      = hit;
  assign res_o.way      = way;
  assign res_o.evicted  = !hit && !free_found;
  assign res_o.tree_new = tree_touch(row_i.tree, way);

endmodule

`default_nettype wire

// ===== src/cwtp_store.sv =====
`default_nettype none

module cwtp_store
  import cwtp_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           upd_i,
  input  wire set_t     set_i,
  input  wire tag_t     tag_i,
  input  wire lookup_t  res_i,
  output set_row_t      row_o,
  output hit_cnt_t      hit_cnt_next_o
);

  tag_t                tag_q   [NUM_SETS][NUM_WAYS];
  logic [NUM_WAYS-1:0] valid_q [NUM_SETS];
  tree_t               tree_q  [NUM_SETS];
  hit_cnt_t            hit_cnt_q;
  hit_cnt_t            hit_cnt_d;

  // Read the addressed set
  always_comb begin
    row_o.valid = valid_q[set_i];
    row_o.tree  = tree_q[set_i];
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_o.tags[w] = tag_q[set_i][w];
    end
  end

  // Saturating hit count
  always_comb begin
    hit_cnt_d = hit_cnt_q;
    if (upd_i && res_i.hit && (hit_cnt_q != '1)) hit_cnt_d = hit_cnt_q + 1'b1;
  end
  assign hit_cnt_next_o = hit_cnt_d;

  // Tag array: written on a miss only, no reset
  always_ff @(posedge clk_i) begin
    if (upd_i && !res_i.hit) begin
      tag_q[set_i][res_i.way] <= tag_i;
    end
  end

  // Valid bits, PLRU trees and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
        tree_q[s]  <= '0;
      end
      hit_cnt_q <= '0;
    end else begin
      if (upd_i) begin
        valid_q[set_i][res_i.way] <= 1'b1;
        tree_q[set_i]             <= res_i.tree_new;
      end
      hit_cnt_q <= hit_cnt_d;
    end
  end

  // Count never goes down
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q >= $past(hit_cnt_q))
    else $error("hit counter decreased");

  // A line touched by an item is valid afterwards
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> valid_q[$past(set_i)][$past(res_i.way)])
    else $error("accessed way not valid");

  // A hit never changes the valid bits of its set
  a_hit_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && res_i.hit |=> valid_q[$past(set_i)] == $past(valid_q[set_i]))
    else $error("hit changed valid bits");

endmodule

`default_nettype wire

// ===== src/four_way_cache_tag_plru.sv =====
// Tag store of a 4-set, 4-way set-associative cache with tree pseudo-LRU
// replacement and a saturating hit counter.
// Input channel: in_valid_i / in_stall_o with address_i; an item is taken
// at a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with hit, way, set, word index,
// tag, eviction flag, tree bits and hit count of one item per address.
// An accepted item goes through the input register, then the lookup and
// update, into the result register.
// Throughput: one item per cycle while out_stall_i is low; the set lookup,
// four-way tag compare and PLRU update sit in one combinational stage
// that reads and writes the set state in the same cycle, so back-to-back
// items to the same set see each other's updates.
// Reset clears all valid bits, PLRU trees and the hit counter; tags are
// not cleared, and no clearing pass is needed.
// When the receiver stalls, the result holds; one more item may wait in
// the input register, after which in_stall_o rises until the result goes.

`default_nettype none

module four_way_cache_tag_plru
  import cwtp_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire [ADDR_W-1:0]     address_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 hit_o,
  output logic [1:0]           way_o,
  output logic [1:0]           set_index_o,
  output logic [WORD_W-1:0]    word_index_o,
  output logic [TAG_WIDTH-1:0] line_tag_o,
  output logic                 evicted_o,
  output logic [2:0]           tree_bits_o,
  output logic [HIT_W-1:0]     hits_so_far_o
);

  logic              in_valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic              accept;
  logic              advance;
  set_t              set_idx;
  tag_t              tag;
  set_row_t          row;
  lookup_t           res;
  hit_cnt_t          hit_cnt_next;

  // Handshake: the input register moves on when the result slot frees
  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) addr_q <= address_i;
  end

  // Address fields
  assign set_idx = addr_q[SET_LSB +: SET_W];
  assign tag     = addr_q[TAG_LSB +: TAG_WIDTH];

  cwtp_store u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (advance),
    .set_i          (set_idx),
    .tag_i          (tag),
    .res_i          (res),
    .row_o          (row),
    .hit_cnt_next_o (hit_cnt_next)
  );

  cwtp_lookup u_lookup (
    .row_i (row),
    .tag_i (tag),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_o         <= res.hit;
      way_o         <= 2'(res.way);
      set_index_o   <= 2'(set_idx);
      word_index_o  <= addr_q[WORD_LSB +: WORD_W];
      line_tag_o    <= tag;
      evicted_o     <= res.evicted;
      tree_bits_o   <= 3'(res.tree_new);
      hits_so_far_o <= hit_cnt_next;
    end
  end

  // A held item in the input register is not dropped while output stalls
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_o && out_stall_i |=> in_valid_q)
    else $error("input item lost during stall");

  // Hit and eviction exclude each other
  a_hit_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit flagged with eviction");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_tag_o)
      && $stable(way_o) && $stable(hits_so_far_o))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/four_way_cache_tag_plru_tb.sv =====
`timescale 1ns / 1ps

module four_way_cache_tag_plru_tb;
  import cwtp_pkg::*;

  // One lookup result as it appears on the output ports
  typedef struct packed {
    logic           hit;
    logic [1:0]     way;
    logic [1:0]     set_index;
    logic [1:0]     word_index;
    tag_t           line_tag;
    logic           evicted;
    logic [2:0]     tree_bits;
    hit_cnt_t       hits_so_far;
  } lookup_result_t;

  // Tracks the tag store contents and queues the lookup results to come
  class lookup_scoreboard;
    tag_t           tags [NUM_SETS][NUM_WAYS];
    bit             valid [NUM_SETS][NUM_WAYS];
    bit [2:0]       trees [NUM_SETS];
    hit_cnt_t       hit_count;
    lookup_result_t pending_lookups [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    hits_seen;
    int unsigned    evictions_seen;

    function new();
      hit_count = '0;
      errors = 0;
      checked = 0;
      hits_seen = 0;
      evictions_seen = 0;
    endfunction

    // Predict the lookup of one accepted address and update the tag store
    function void note_access(logic [ADDR_W-1:0] addr);
      lookup_result_t r;
      int unsigned    s;
      bit             found;
      r = '0;
      s = addr[5:4];
      r.set_index = addr[5:4];
      r.word_index = addr[3:2];
      r.line_tag = addr[31:6];
      found = 1'b0;
      // lowest valid way with a matching tag
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!found && valid[s][w] && tags[s][w] == r.line_tag) begin
          found = 1'b1;
          r.way = 2'(w);
        end
      end
      r.hit = found;
      if (!found) begin
        // lowest free way, else the pseudo-LRU victim
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!found && !valid[s][w]) begin
            found = 1'b1;
            r.way = 2'(w);
          end
        end
        if (!found) begin
          if (trees[s][0]) r.way = trees[s][1] ? 2'd0 : 2'd1;
          else             r.way = trees[s][2] ? 2'd2 : 2'd3;
          r.evicted = 1'b1;
        end
        tags[s][r.way] = r.line_tag;
        valid[s][r.way] = 1'b1;
      end else if (hit_count != '1) begin
        hit_count++;
      end
      // root points at the half, the leaf node at the way within it
      trees[s][0] = r.way[1];
      trees[s][r.way[1] ? 2 : 1] = r.way[0];
      r.tree_bits = trees[s];
      r.hits_so_far = hit_count;
      pending_lookups = {pending_lookups, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_lookup(lookup_result_t act);
      lookup_result_t exp_r;
      if (pending_lookups.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, act);
        return;
      end
      exp_r = pending_lookups.pop_front();
      checked++;
      if (exp_r.hit) hits_seen++;
      if (exp_r.evicted) evictions_seen++;
      compare_field("hit", exp_r.hit, act.hit);
      compare_field("way", exp_r.way, act.way);
      compare_field("set_index", exp_r.set_index, act.set_index);
      compare_field("word_index", exp_r.word_index, act.word_index);
      compare_field("line_tag", exp_r.line_tag, act.line_tag);
      compare_field("evicted", exp_r.evicted, act.evicted);
      compare_field("tree_bits", exp_r.tree_bits, act.tree_bits);
      compare_field("hits_so_far", exp_r.hits_so_far, act.hits_so_far);
    endfunction

    function int unsigned outstanding();
      return pending_lookups.size();
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned POOL_TAGS    = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ADDR_W-1:0]    address_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 hit_o;
  logic [1:0]           way_o;
  logic [1:0]           set_index_o;
  logic [WORD_W-1:0]    word_index_o;
  logic [TAG_WIDTH-1:0] line_tag_o;
  logic                 evicted_o;
  logic [2:0]           tree_bits_o;
  logic [HIT_W-1:0]     hits_so_far_o;

  lookup_scoreboard lookups = new();

  bit          hold_off;        // main asks the receiver for a long stall
  bit          quiet_receiver;  // receiver never stalls
  int unsigned input_stalls;
  tag_t        tag_pool [NUM_SETS][POOL_TAGS];

  four_way_cache_tag_plru dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .way_o         (way_o),
    .set_index_o   (set_index_o),
    .word_index_o  (word_index_o),
    .line_tag_o    (line_tag_o),
    .evicted_o     (evicted_o),
    .tree_bits_o   (tree_bits_o),
    .hits_so_far_o (hits_so_far_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watch both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) input_stalls++;
      if (in_valid_i && !in_stall_o) lookups.note_access(address_i);
      if (out_valid_o && !out_stall_i)
        lookups.check_lookup({hit_o, way_o, set_index_o, word_index_o, line_tag_o,
                              evicted_o, tree_bits_o, hits_so_far_o});
    end
  end

  // Receiver: random stall runs, a long hold on request, or none at all
  initial begin
    int unsigned run_len;
    bit          stalling;
    run_len = 0;
    stalling = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (quiet_receiver) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_len == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run_len = stalling ? $urandom_range(1, 6) : $urandom_range(1, 16);
        end
        run_len--;
        out_stall_i <= stalling;
      end
    end
  end

  // Offer one address and hold it until accepted
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Leave the input idle; n sets the length of the gap, and zero skips it
  task automatic drop_valid(input int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] line_addr(tag_t tag, set_t s, logic [1:0] word);
    return {tag, s, word, 2'($urandom_range(0, 3))};
  endfunction

  // Mostly pooled tags so lines get reused; the rest fully random
  function automatic logic [ADDR_W-1:0] random_addr();
    set_t s;
    s = set_t'($urandom_range(0, NUM_SETS - 1));
    if ($urandom_range(0, 3) == 0) return $urandom;
    return line_addr(tag_pool[s][$urandom_range(0, POOL_TAGS - 1)], s,
                     2'($urandom_range(0, 3)));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          pressured;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    address_i = '0;
    hold_off = 1'b0;
    quiet_receiver = 1'b0;
    input_stalls = 0;
    pressured = 1'b0;
    for (int s = 0; s < NUM_SETS; s++)
      for (int t = 0; t < POOL_TAGS; t++)
        tag_pool[s][t] = tag_t'($urandom);
    tag_pool[0][0] = '0;
    tag_pool[3][0] = '1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, fills, hits and replacement
    send_address(32'h0000_0000);
    send_address(32'h0000_000C);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFF0);
    for (int t = 1; t <= 4; t++) send_address(line_addr(tag_t'(t), 2'd1, 2'(t)));
    send_address(line_addr(tag_t'(2), 2'd1, 2'd0));
    send_address(line_addr(tag_t'(5), 2'd1, 2'd1));
    send_address(line_addr(tag_t'(6), 2'd1, 2'd2));
    send_address(line_addr(tag_t'(1), 2'd1, 2'd3));
    send_address(line_addr(tag_t'(3), 2'd1, 2'd0));
    send_address(line_addr(26'h2AA_AAAA, 2'd2, 2'd1));
    send_address(line_addr(26'h155_5555, 2'd2, 2'd2));
    send_address(line_addr(26'h2AA_AAAA, 2'd2, 2'd3));
    send_address(line_addr('1, 2'd0, 2'd0));
    send_address(line_addr('0, 2'd3, 2'd3));
    send_address(line_addr(26'h000_0001, 2'd2, 2'd0));
    send_address(line_addr(26'h200_0000, 2'd2, 2'd1));
    send_address(line_addr(26'h155_5555, 2'd2, 2'd2));
    drop_valid(3);

    // Random bursts; halfway a long receiver hold with the sender pushing on
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (!pressured && sent >= RANDOM_ITEMS / 2) begin
        pressured = 1'b1;
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++) send_address(random_addr());
        sent += 40;
      end
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) send_address(random_addr());
      sent += burst;
      drop_valid($urandom_range(0, 5));
    end

    // Back-to-back fills and hits with the receiver always ready
    quiet_receiver = 1'b1;
    for (int s = 0; s < NUM_SETS; s++) send_address(line_addr(26'h0F0_F0F0, set_t'(s), 2'd0));
    for (int i = 0; i < 12; i++)
      send_address(line_addr(26'h0F0_F0F0, set_t'(i % NUM_SETS), 2'(i)));
    drop_valid(1);

    while (lookups.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("checked %0d lookups: %0d hits, %0d evictions, hit count %0d",
             lookups.checked, lookups.hits_seen, lookups.evictions_seen, lookups.hit_count);
    $display("input held off for %0d cycles under receiver back-pressure", input_stalls);
    if (lookups.errors == 0) begin
      $display("four_way_cache_tag_plru_tb: done, clean");
    end else begin
      $display("four_way_cache_tag_plru_tb: done, errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(20_000_000);
    $display("timeout with %0d results outstanding", lookups.outstanding());
    $display("four_way_cache_tag_plru_tb: done, errors");
    $finish;
  end

endmodule
